// ===== sv/tapq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport package
// Shared widths, command and register codes, state types and the clamping
// functions of the tempo-anchored ppq transport.
// ----------------------------------------------------------------------------
package tapq_pkg;

    localparam int unsigned POSITION_BITS_DEF     = 48;
    localparam int unsigned PPQ_FRACTION_BITS_DEF = 24;

    localparam int unsigned CMD_W     = 4;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned BLK_W     = COUNT_W - 1;
    localparam int unsigned RATE_W    = 20;
    localparam int unsigned TEMPO_W   = 17;
    localparam int unsigned DIV_W     = RATE_W + 6;
    localparam int unsigned CFG_W     = RATE_W;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [RATE_W-1:0]  RATE_RESET  = 20'd44100;
    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 17'd30720;
    localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 17'd5120;
    localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 17'd76800;

    typedef enum logic [CMD_W-1:0] {
        CMD_PREPARE   = 4'd0,
        CMD_SET_RATE  = 4'd1,
        CMD_SET_TEMPO = 4'd2,
        CMD_START     = 4'd3,
        CMD_STOP      = 4'd4,
        CMD_CONTINUE  = 4'd5,
        CMD_BEGIN_BLK = 4'd6,
        CMD_END_BLK   = 4'd7,
        CMD_SET_POS   = 4'd8,
        CMD_RESET     = 4'd9
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE = 1'b0,
        CFG_TEMPO       = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_LAUNCH_A,
        S_WAIT_A,
        S_LAUNCH_B,
        S_WAIT_B,
        S_RESULT
    } t_ctl_state;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL_LO,
        U_MUL_HI,
        U_DIV,
        U_FIN
    } t_unit_state;

    function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
        return (r == '0) ? RATE_W'(1) : r;
    endfunction

    function automatic logic [TEMPO_W-1:0] clamp_tempo(input logic [TEMPO_W-1:0] t);
        logic [TEMPO_W-1:0] c;
        if (t < TEMPO_MIN) begin
            c = TEMPO_MIN;
        end else if (t > TEMPO_MAX) begin
            c = TEMPO_MAX;
        end else begin
            c = t;
        end
        return c;
    endfunction

endpackage

// ===== sv/tapq_ppq_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ppq evaluation unit
// Converts a sample index to a ppq position from the anchor pair with one
// shared multiplier used twice and a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module tapq_ppq_unit #(
    parameter int unsigned POSITION_BITS     = tapq_pkg::POSITION_BITS_DEF,
    parameter int unsigned PPQ_FRACTION_BITS = tapq_pkg::PPQ_FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [POSITION_BITS-1:0]          i_sample,
    input  logic [POSITION_BITS-1:0]          i_anchor_sample,
    input  logic [POSITION_BITS-1:0]          i_anchor_ppq,
    input  logic [tapq_pkg::TEMPO_W-1:0]      i_tempo,
    input  logic [tapq_pkg::RATE_W-1:0]       i_rate,
    output logic                              o_done,
    output logic [POSITION_BITS-1:0]          o_ppq
);

    localparam int unsigned SH     = PPQ_FRACTION_BITS - 8;
    localparam int unsigned NUM_W  = POSITION_BITS + tapq_pkg::TEMPO_W + SH;
    localparam int unsigned LO_W   = (POSITION_BITS + 1) / 2;
    localparam int unsigned PROD_W = LO_W + tapq_pkg::TEMPO_W;
    localparam int unsigned CNT_W  = $clog2(NUM_W);
    localparam int unsigned DIV_W  = tapq_pkg::DIV_W;

    tapq_pkg::t_unit_state r_state, n_state;

    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic                     r_neg, n_neg;
    logic [POSITION_BITS-1:0] r_mag, n_mag;
    logic [DIV_W-1:0]         r_div, n_div;
    logic [NUM_W-1:0]         r_num, n_num;
    logic [DIV_W-1:0]         r_rem, n_rem;
    logic [POSITION_BITS-1:0] r_q, n_q;

    logic [POSITION_BITS-1:0] diff;
    logic [LO_W-1:0]          mul_a;
    logic [PROD_W-1:0]        mul_p;
    logic [DIV_W:0]           rem_sh;
    logic [DIV_W:0]           rem_sub;
    logic                     rem_ge;

    assign diff    = i_sample - i_anchor_sample;
    assign mul_a   = (r_state == tapq_pkg::U_MUL_LO) ? r_mag[LO_W-1:0]
                                                     : LO_W'(r_mag[POSITION_BITS-1:LO_W]);
    assign mul_p   = mul_a * i_tempo;
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tapq_pkg::U_IDLE: begin
                if (i_start) begin
                    n_state = tapq_pkg::U_MUL_LO;
                end
            end
            tapq_pkg::U_MUL_LO: n_state = tapq_pkg::U_MUL_HI;
            tapq_pkg::U_MUL_HI: n_state = tapq_pkg::U_DIV;
            tapq_pkg::U_DIV: begin
                if (r_cnt == '0) begin
                    n_state = tapq_pkg::U_FIN;
                end
            end
            tapq_pkg::U_FIN: n_state = tapq_pkg::U_IDLE;
            default: n_state = tapq_pkg::U_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_state == tapq_pkg::U_FIN);
        o_ppq  = i_anchor_ppq + (r_q ^ {POSITION_BITS{r_neg}}) + POSITION_BITS'(r_neg);
    end

    always_comb begin
        n_cnt = r_cnt;
        n_neg = r_neg;
        n_mag = r_mag;
        n_div = r_div;
        n_num = r_num;
        n_rem = r_rem;
        n_q   = r_q;
        unique case (r_state)
            tapq_pkg::U_IDLE: begin
                n_neg = diff[POSITION_BITS-1];
                n_mag = diff[POSITION_BITS-1] ? (~diff + POSITION_BITS'(1)) : diff;
                n_div = DIV_W'({i_rate, 6'b0}) - DIV_W'({i_rate, 2'b0});
                n_rem = '0;
                n_q   = '0;
                n_cnt = CNT_W'(NUM_W - 1);
            end
            tapq_pkg::U_MUL_LO: begin
                n_num = NUM_W'(mul_p) << SH;
            end
            tapq_pkg::U_MUL_HI: begin
                n_num = r_num + (NUM_W'(mul_p) << (LO_W + SH));
            end
            tapq_pkg::U_DIV: begin
                n_rem = rem_ge ? DIV_W'(rem_sub) : DIV_W'(rem_sh);
                n_q   = {r_q[POSITION_BITS-2:0], rem_ge};
                n_num = r_num << 1;
                n_cnt = r_cnt - CNT_W'(1);
            end
            tapq_pkg::U_FIN: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tapq_pkg::U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_neg <= n_neg;
        r_mag <= n_mag;
        r_div <= n_div;
        r_num <= n_num;
        r_rem <= n_rem;
        r_q   <= n_q;
    end

endmodule

// ===== sv/tempo_anchored_ppq_transport_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tempo-anchored ppq transport core
// Tracks a wrapping sample counter and an anchor pair and reports the ppq
// window of the current audio block after every command beat.
// ----------------------------------------------------------------------------
// Commands without a ppq evaluation pass from the beat through the execute
// and result states to the output register. Each ppq evaluation holds the
// shared divider; set rate or tempo needs one if the value changes, end block
// one while running, begin block one, two while running. One command at a time.
// After reset S_INIT loads rate and tempo from the configuration registers.
module tempo_anchored_ppq_transport_core #(
    parameter int unsigned POSITION_BITS     = tapq_pkg::POSITION_BITS_DEF,
    parameter int unsigned PPQ_FRACTION_BITS = tapq_pkg::PPQ_FRACTION_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tapq_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tapq_pkg::CFG_W-1:0]             i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [tapq_pkg::CMD_W-1:0]             i_cmd,
    input  logic signed [tapq_pkg::COUNT_W-1:0]    i_sample_count,
    input  logic [tapq_pkg::RATE_W-1:0]            i_rate_hz,
    input  logic [tapq_pkg::TEMPO_W-1:0]           i_tempo_bpm,
    input  logic signed [POSITION_BITS-1:0]        i_position_ppq,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [POSITION_BITS-1:0]        o_window_start_ppq,
    output logic signed [POSITION_BITS-1:0]        o_window_end_ppq,
    output logic [POSITION_BITS-1:0]               o_sample_position,
    output logic                                   o_is_playing
);

    localparam int unsigned P     = POSITION_BITS;
    localparam int unsigned BLK_W = tapq_pkg::BLK_W;

    tapq_pkg::t_ctl_state r_state, n_state;

    tapq_pkg::t_cmd                  r_cmd;
    logic [tapq_pkg::COUNT_W-1:0]    r_cnt_in;
    logic [tapq_pkg::RATE_W-1:0]     r_rate_in;
    logic [tapq_pkg::TEMPO_W-1:0]    r_tempo_in;
    logic [P-1:0]                    r_pos_in;

    logic [tapq_pkg::RATE_W-1:0]     r_cfg_rate;
    logic [tapq_pkg::TEMPO_W-1:0]    r_cfg_tempo;

    logic [P-1:0]                    r_counter, n_counter;
    logic [P-1:0]                    r_anchor_sample, n_anchor_sample;
    logic [P-1:0]                    r_anchor_ppq, n_anchor_ppq;
    logic [P-1:0]                    r_start_ppq, n_start_ppq;
    logic [P-1:0]                    r_end_ppq, n_end_ppq;
    logic [BLK_W-1:0]                r_block_len, n_block_len;
    logic                            r_running, n_running;
    logic [tapq_pkg::RATE_W-1:0]     r_rate, n_rate;
    logic [tapq_pkg::TEMPO_W-1:0]    r_tempo, n_tempo;

    logic                            r_out_valid;
    logic [P-1:0]                    r_out_start;
    logic [P-1:0]                    r_out_end;
    logic [P-1:0]                    r_out_pos;
    logic                            r_out_play;

    logic [tapq_pkg::RATE_W-1:0]     rate_c;
    logic [tapq_pkg::TEMPO_W-1:0]    tempo_c;
    logic                            out_free;
    logic                            out_load;
    logic                            in_ready;
    logic                            unit_start;
    logic                            unit_done;
    logic [P-1:0]                    unit_sample;
    logic [P-1:0]                    unit_ppq;

    assign rate_c   = tapq_pkg::clamp_rate(r_rate_in);
    assign tempo_c  = tapq_pkg::clamp_tempo(r_tempo_in);
    assign out_free = !r_out_valid || i_out_ready;

    tapq_ppq_unit #(
        .POSITION_BITS     (POSITION_BITS),
        .PPQ_FRACTION_BITS (PPQ_FRACTION_BITS)
    ) u_ppq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (unit_start),
        .i_sample        (unit_sample),
        .i_anchor_sample (r_anchor_sample),
        .i_anchor_ppq    (r_anchor_ppq),
        .i_tempo         (r_tempo),
        .i_rate          (r_rate),
        .o_done          (unit_done),
        .o_ppq           (unit_ppq)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tapq_pkg::S_INIT: n_state = tapq_pkg::S_IDLE;
            tapq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tapq_pkg::S_EXEC;
                end
            end
            tapq_pkg::S_EXEC: begin
                unique case (r_cmd)
                    tapq_pkg::CMD_SET_RATE: begin
                        n_state = (rate_c != r_rate) ? tapq_pkg::S_LAUNCH_A
                                                     : tapq_pkg::S_RESULT;
                    end
                    tapq_pkg::CMD_SET_TEMPO: begin
                        n_state = (tempo_c != r_tempo) ? tapq_pkg::S_LAUNCH_A
                                                       : tapq_pkg::S_RESULT;
                    end
                    tapq_pkg::CMD_BEGIN_BLK: n_state = tapq_pkg::S_LAUNCH_A;
                    tapq_pkg::CMD_END_BLK: begin
                        n_state = r_running ? tapq_pkg::S_LAUNCH_A : tapq_pkg::S_RESULT;
                    end
                    default: n_state = tapq_pkg::S_RESULT;
                endcase
            end
            tapq_pkg::S_LAUNCH_A: n_state = tapq_pkg::S_WAIT_A;
            tapq_pkg::S_WAIT_A: begin
                if (unit_done) begin
                    n_state = (r_cmd == tapq_pkg::CMD_BEGIN_BLK && r_running)
                            ? tapq_pkg::S_LAUNCH_B : tapq_pkg::S_RESULT;
                end
            end
            tapq_pkg::S_LAUNCH_B: n_state = tapq_pkg::S_WAIT_B;
            tapq_pkg::S_WAIT_B: begin
                if (unit_done) begin
                    n_state = tapq_pkg::S_RESULT;
                end
            end
            tapq_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = tapq_pkg::S_IDLE;
                end
            end
            default: n_state = tapq_pkg::S_INIT;
        endcase
    end

    always_comb begin
        in_ready    = (r_state == tapq_pkg::S_IDLE);
        unit_start  = (r_state == tapq_pkg::S_LAUNCH_A) || (r_state == tapq_pkg::S_LAUNCH_B);
        out_load    = (r_state == tapq_pkg::S_RESULT) && out_free;
        unit_sample = (r_state == tapq_pkg::S_LAUNCH_B) ? (r_counter + P'(r_block_len))
                                                        : r_counter;
    end

    always_comb begin
        n_counter       = r_counter;
        n_anchor_sample = r_anchor_sample;
        n_anchor_ppq    = r_anchor_ppq;
        n_start_ppq     = r_start_ppq;
        n_end_ppq       = r_end_ppq;
        n_block_len     = r_block_len;
        n_running       = r_running;
        n_rate          = r_rate;
        n_tempo         = r_tempo;
        unique case (r_state)
            tapq_pkg::S_INIT: begin
                n_rate  = tapq_pkg::clamp_rate(r_cfg_rate);
                n_tempo = tapq_pkg::clamp_tempo(r_cfg_tempo);
            end
            tapq_pkg::S_EXEC: begin
                unique case (r_cmd)
                    tapq_pkg::CMD_PREPARE, tapq_pkg::CMD_RESET: begin
                        if (r_cmd == tapq_pkg::CMD_PREPARE) begin
                            n_rate = rate_c;
                        end
                        n_counter       = '0;
                        n_anchor_sample = '0;
                        n_anchor_ppq    = '0;
                        n_start_ppq     = '0;
                        n_end_ppq       = '0;
                        n_block_len     = '0;
                        n_running       = 1'b0;
                    end
                    tapq_pkg::CMD_START: begin
                        n_counter       = '0;
                        n_anchor_sample = '0;
                        n_anchor_ppq    = '0;
                        n_start_ppq     = '0;
                        n_end_ppq       = '0;
                        n_running       = 1'b1;
                    end
                    tapq_pkg::CMD_STOP:     n_running = 1'b0;
                    tapq_pkg::CMD_CONTINUE: n_running = 1'b1;
                    tapq_pkg::CMD_BEGIN_BLK: begin
                        n_block_len = r_cnt_in[tapq_pkg::COUNT_W-1] ? '0 : r_cnt_in[BLK_W-1:0];
                    end
                    tapq_pkg::CMD_END_BLK: begin
                        if (r_running) begin
                            n_counter = r_counter + P'(r_block_len);
                        end
                    end
                    tapq_pkg::CMD_SET_POS: begin
                        n_anchor_ppq    = r_pos_in;
                        n_anchor_sample = r_counter;
                        n_start_ppq     = r_pos_in;
                        n_end_ppq       = r_pos_in;
                    end
                    default: begin
                    end
                endcase
            end
            tapq_pkg::S_WAIT_A: begin
                if (unit_done) begin
                    unique case (r_cmd)
                        tapq_pkg::CMD_SET_RATE: begin
                            n_anchor_ppq    = unit_ppq;
                            n_anchor_sample = r_counter;
                            n_rate          = rate_c;
                        end
                        tapq_pkg::CMD_SET_TEMPO: begin
                            n_anchor_ppq    = unit_ppq;
                            n_anchor_sample = r_counter;
                            n_tempo         = tempo_c;
                        end
                        tapq_pkg::CMD_BEGIN_BLK: begin
                            n_start_ppq = unit_ppq;
                            if (!r_running) begin
                                n_end_ppq = unit_ppq;
                            end
                        end
                        tapq_pkg::CMD_END_BLK: begin
                            n_start_ppq = unit_ppq;
                            n_end_ppq   = unit_ppq;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tapq_pkg::S_WAIT_B: begin
                if (unit_done) begin
                    n_end_ppq = unit_ppq;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= tapq_pkg::S_INIT;
            r_counter       <= '0;
            r_anchor_sample <= '0;
            r_anchor_ppq    <= '0;
            r_start_ppq     <= '0;
            r_end_ppq       <= '0;
            r_block_len     <= '0;
            r_running       <= 1'b0;
            r_rate          <= tapq_pkg::RATE_RESET;
            r_tempo         <= tapq_pkg::TEMPO_RESET;
        end else begin
            r_state         <= n_state;
            r_counter       <= n_counter;
            r_anchor_sample <= n_anchor_sample;
            r_anchor_ppq    <= n_anchor_ppq;
            r_start_ppq     <= n_start_ppq;
            r_end_ppq       <= n_end_ppq;
            r_block_len     <= n_block_len;
            r_running       <= n_running;
            r_rate          <= n_rate;
            r_tempo         <= n_tempo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rate  <= tapq_pkg::RATE_RESET;
            r_cfg_tempo <= tapq_pkg::TEMPO_RESET;
        end else if (i_cfg_we) begin
            unique case (tapq_pkg::t_cfg_idx'(i_cfg_idx))
                tapq_pkg::CFG_SAMPLE_RATE: r_cfg_rate  <= i_cfg_data[tapq_pkg::RATE_W-1:0];
                tapq_pkg::CFG_TEMPO:       r_cfg_tempo <= i_cfg_data[tapq_pkg::TEMPO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_cmd      <= tapq_pkg::t_cmd'(i_cmd);
            r_cnt_in   <= i_sample_count;
            r_rate_in  <= i_rate_hz;
            r_tempo_in <= i_tempo_bpm;
            r_pos_in   <= i_position_ppq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_start <= r_start_ppq;
            r_out_end   <= r_end_ppq;
            r_out_pos   <= r_counter;
            r_out_play  <= r_running;
        end
    end

    assign o_in_ready         = in_ready;
    assign o_out_valid        = r_out_valid;
    assign o_window_start_ppq = r_out_start;
    assign o_window_end_ppq   = r_out_end;
    assign o_sample_position  = r_out_pos;
    assign o_is_playing       = r_out_play;

endmodule

// ===== sv/tapq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport port checker
// Watches the ports of the transport core for handshake and sequencing rules.
// ----------------------------------------------------------------------------
module tapq_checker #(
    parameter int unsigned POSITION_BITS = tapq_pkg::POSITION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [POSITION_BITS-1:0]     o_window_start_ppq,
    input  logic signed [POSITION_BITS-1:0]     o_window_end_ppq,
    input  logic [POSITION_BITS-1:0]            o_sample_position,
    input  logic                                o_is_playing
);

    // Reset leaves no result pending and holds off input while S_INIT loads.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("result or ready visible right after reset");

    // A command beat makes the block busy on the next cycle.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("block ready again directly after a command beat");

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_window_start_ppq)
            && $stable(o_window_end_ppq) && $stable(o_sample_position)
            && $stable(o_is_playing))
        else $error("stalled result beat changed or dropped");

endmodule

bind tempo_anchored_ppq_transport_core tapq_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_tapq_checker (.*);

// ===== verif/tb_tempo_anchored_ppq_transport_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transport core testbench
// Drives command beats into the tempo-anchored ppq transport through a short
// directed list and a long run of random play sessions and single commands.
// A local model predicts each window not given by a directed row; each returned
// window is compared field by field while both handshake sides stall at random.
// ----------------------------------------------------------------------------
module tb_tempo_anchored_ppq_transport_core;

    localparam int unsigned POS_W     = tapq_pkg::POSITION_BITS_DEF;
    localparam int unsigned FRAC_W    = tapq_pkg::PPQ_FRACTION_BITS_DEF;
    localparam int unsigned CMD_W     = tapq_pkg::CMD_W;
    localparam int unsigned COUNT_W   = tapq_pkg::COUNT_W;
    localparam int unsigned RATE_W    = tapq_pkg::RATE_W;
    localparam int unsigned TEMPO_W   = tapq_pkg::TEMPO_W;
    localparam int unsigned CFG_W     = tapq_pkg::CFG_W;
    localparam int unsigned CFG_IDX_W = tapq_pkg::CFG_IDX_W;

    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
    localparam logic [POS_W-1:0] PPQ_ONE       = 48'h00_0001_000000;
    localparam int               HOLD_CYCLES   = 400;

    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic signed [COUNT_W-1:0] count;
        logic [RATE_W-1:0]         rate;
        logic [TEMPO_W-1:0]        tempo;
        logic [POS_W-1:0]          pos;
    } t_transport_cmd;

    typedef struct {
        logic [POS_W-1:0] win_start;
        logic [POS_W-1:0] win_end;
        logic [POS_W-1:0] smp_pos;
        logic             playing;
    } t_window;

    typedef struct {
        t_transport_cmd beat;
        bit             typed;
        t_window        want;
    } t_dir_row;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [CMD_W-1:0]          i_cmd;
    logic signed [COUNT_W-1:0] i_sample_count;
    logic [RATE_W-1:0]         i_rate_hz;
    logic [TEMPO_W-1:0]        i_tempo_bpm;
    logic signed [POS_W-1:0]   i_position_ppq;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [POS_W-1:0]   o_window_start_ppq;
    logic signed [POS_W-1:0]   o_window_end_ppq;
    logic [POS_W-1:0]          o_sample_position;
    logic                      o_is_playing;

    // Local copy of the transport state and of the configuration registers.
    logic [POS_W-1:0]   tr_counter;
    logic [POS_W-1:0]   tr_anchor_smp;
    logic [POS_W-1:0]   tr_anchor_ppq;
    logic [POS_W-1:0]   tr_start;
    logic [POS_W-1:0]   tr_end;
    logic [COUNT_W-1:0] tr_blk_len;
    logic               tr_running;
    logic [RATE_W-1:0]  tr_rate;
    logic [TEMPO_W-1:0] tr_tempo;
    logic [RATE_W-1:0]  cfg_rate  = tapq_pkg::RATE_RESET;
    logic [TEMPO_W-1:0] cfg_tempo = tapq_pkg::TEMPO_RESET;

    t_window  pending_windows[$];
    t_dir_row directed_rows[$];
    t_window  no_window;
    t_window  got_window;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    bit hold_off_armed = 1'b0;
    bit hold_off_done  = 1'b0;

    int mismatch_count  = 0;
    int cmds_sent       = 0;
    int windows_checked = 0;
    int blocks_played   = 0;
    int anchors_moved   = 0;
    int reg_writes      = 0;

    tempo_anchored_ppq_transport_core #(
        .POSITION_BITS     (POS_W),
        .PPQ_FRACTION_BITS (FRAC_W)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_sample_count     (i_sample_count),
        .i_rate_hz          (i_rate_hz),
        .i_tempo_bpm        (i_tempo_bpm),
        .i_position_ppq     (i_position_ppq),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_window_start_ppq (o_window_start_ppq),
        .o_window_end_ppq   (o_window_end_ppq),
        .o_sample_position  (o_sample_position),
        .o_is_playing       (o_is_playing)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [RATE_W-1:0] bound_rate(input logic [RATE_W-1:0] r);
        return (r == '0) ? RATE_W'(1) : r;
    endfunction

    function automatic logic [TEMPO_W-1:0] bound_tempo(input logic [TEMPO_W-1:0] t);
        if (t < tapq_pkg::TEMPO_MIN) begin
            return tapq_pkg::TEMPO_MIN;
        end
        if (t > tapq_pkg::TEMPO_MAX) begin
            return tapq_pkg::TEMPO_MAX;
        end
        return t;
    endfunction

    function automatic logic [POS_W-1:0] ppq_at_sample(input logic [POS_W-1:0] smp);
        logic [POS_W-1:0] delta;
        logic [POS_W-1:0] mag;
        logic [POS_W-1:0] quo;
        logic [95:0]      num;
        logic [95:0]      divisor;
        logic [95:0]      full_quo;
        delta    = smp - tr_anchor_smp;
        mag      = delta[POS_W-1] ? -delta : delta;
        num      = 96'(mag) * 96'(tr_tempo);
        num      = num << (FRAC_W - 8);
        divisor  = 96'(tr_rate) * 96'd60;
        full_quo = num / divisor;
        quo      = full_quo[POS_W-1:0];
        if (delta[POS_W-1]) begin
            quo = -quo;
        end
        return tr_anchor_ppq + quo;
    endfunction

    function automatic void move_anchor();
        tr_anchor_ppq = ppq_at_sample(tr_counter);
        tr_anchor_smp = tr_counter;
        anchors_moved++;
    endfunction

    function automatic void clear_transport_state();
        tr_counter    = '0;
        tr_anchor_smp = '0;
        tr_anchor_ppq = '0;
        tr_start      = '0;
        tr_end        = '0;
        tr_blk_len    = '0;
        tr_running    = 1'b0;
    endfunction

    function automatic void retime_rate(input logic [RATE_W-1:0] r);
        logic [RATE_W-1:0] c;
        c = bound_rate(r);
        if (c != tr_rate) begin
            move_anchor();
            tr_rate = c;
        end
    endfunction

    function automatic t_window advance_transport(input t_transport_cmd c);
        t_window          w;
        logic [TEMPO_W-1:0] tc;
        case (c.cmd)
            tapq_pkg::CMD_PREPARE: begin
                retime_rate(c.rate);
                clear_transport_state();
            end
            tapq_pkg::CMD_SET_RATE: begin
                retime_rate(c.rate);
            end
            tapq_pkg::CMD_SET_TEMPO: begin
                tc = bound_tempo(c.tempo);
                if (tc != tr_tempo) begin
                    move_anchor();
                    tr_tempo = tc;
                end
            end
            tapq_pkg::CMD_START: begin
                tr_counter    = '0;
                tr_anchor_smp = '0;
                tr_anchor_ppq = '0;
                tr_start      = '0;
                tr_end        = '0;
                tr_running    = 1'b1;
            end
            tapq_pkg::CMD_STOP: begin
                tr_running = 1'b0;
            end
            tapq_pkg::CMD_CONTINUE: begin
                tr_running = 1'b1;
            end
            tapq_pkg::CMD_BEGIN_BLK: begin
                tr_blk_len = c.count[COUNT_W-1] ? '0 : c.count;
                tr_start   = ppq_at_sample(tr_counter);
                tr_end     = tr_running ? ppq_at_sample(tr_counter + POS_W'(tr_blk_len))
                                        : tr_start;
            end
            tapq_pkg::CMD_END_BLK: begin
                if (tr_running) begin
                    tr_counter = tr_counter + POS_W'(tr_blk_len);
                    tr_start   = ppq_at_sample(tr_counter);
                    tr_end     = tr_start;
                end
            end
            tapq_pkg::CMD_SET_POS: begin
                tr_anchor_ppq = c.pos;
                tr_anchor_smp = tr_counter;
                tr_start      = c.pos;
                tr_end        = c.pos;
            end
            tapq_pkg::CMD_RESET: begin
                clear_transport_state();
            end
            default: begin
            end
        endcase
        w.win_start = tr_start;
        w.win_end   = tr_end;
        w.smp_pos   = tr_counter;
        w.playing   = tr_running;
        return w;
    endfunction

    task automatic flag_mismatch(input string what, input logic [POS_W-1:0] got,
                                 input logic [POS_W-1:0] want);
        $display("mismatch %s: got %h want %h (window %0d, t=%0t)",
                 what, got, want, windows_checked, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_windows.size() == 0) begin
                flag_mismatch("window with none outstanding", o_window_start_ppq, '0);
            end else begin
                got_window = pending_windows.pop_front();
                if (o_window_start_ppq !== got_window.win_start) begin
                    flag_mismatch("window_start_ppq", o_window_start_ppq,
                                  got_window.win_start);
                end
                if (o_window_end_ppq !== got_window.win_end) begin
                    flag_mismatch("window_end_ppq", o_window_end_ppq, got_window.win_end);
                end
                if (o_sample_position !== got_window.smp_pos) begin
                    flag_mismatch("sample_position", o_sample_position, got_window.smp_pos);
                end
                if (o_is_playing !== got_window.playing) begin
                    flag_mismatch("is_playing", POS_W'(o_is_playing),
                                  POS_W'(got_window.playing));
                end
            end
            windows_checked++;
        end
    end

    // The output side: random back-pressure, plus one long hold-off when armed.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_armed && !hold_off_done) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_done = 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_cmd(input t_transport_cmd c, input bit typed, input t_window want);
        t_window predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_cmd          <= c.cmd;
        i_sample_count <= c.count;
        i_rate_hz      <= c.rate;
        i_tempo_bpm    <= c.tempo;
        i_position_ppq <= c.pos;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        if (c.cmd == tapq_pkg::CMD_BEGIN_BLK && tr_running) begin
            blocks_played++;
        end
        if (c.cmd <= tapq_pkg::CMD_RESET) begin
            cmds_sent++;
        end
        predicted = advance_transport(c);
        pending_windows.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input tapq_pkg::t_cfg_idx idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        if (idx == tapq_pkg::CFG_SAMPLE_RATE) begin
            cfg_rate = data;
        end else begin
            cfg_tempo = data[TEMPO_W-1:0];
        end
        reg_writes++;
    endtask

    task automatic wait_windows_drained();
        int guard;
        guard = 0;
        i_in_valid <= 1'b0;
        while (pending_windows.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    function automatic void dir_row(input logic [CMD_W-1:0] cmd,
                                    input logic signed [COUNT_W-1:0] count,
                                    input logic [RATE_W-1:0] rate,
                                    input logic [TEMPO_W-1:0] tempo,
                                    input logic [POS_W-1:0] pos, input bit typed,
                                    input logic [POS_W-1:0] ws, input logic [POS_W-1:0] we,
                                    input logic [POS_W-1:0] sp, input logic pl);
        t_dir_row r;
        r.beat.cmd     = cmd;
        r.beat.count   = count;
        r.beat.rate    = rate;
        r.beat.tempo   = tempo;
        r.beat.pos     = pos;
        r.typed        = typed;
        r.want.win_start = ws;
        r.want.win_end   = we;
        r.want.smp_pos   = sp;
        r.want.playing   = pl;
        directed_rows.push_back(r);
    endfunction

    function automatic t_transport_cmd random_cmd(input logic [CMD_W-1:0] cmd);
        t_transport_cmd c;
        c.cmd   = cmd;
        c.count = COUNT_W'($urandom);
        c.rate  = RATE_W'($urandom);
        c.tempo = TEMPO_W'($urandom);
        c.pos   = POS_W'({$urandom, $urandom});
        return c;
    endfunction

    function automatic logic signed [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return COUNT_W'($urandom_range(4096, 1));
        end else if (r < 75) begin
            return COUNT_W'($urandom_range(32767));
        end else if (r < 85) begin
            return '0;
        end
        return COUNT_W'($urandom);
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int r;
        r = $urandom_range(99);
        if (r < 10) begin
            return tr_rate;
        end else if (r < 15) begin
            return '0;
        end else if (r < 20) begin
            return '1;
        end else if (r < 60) begin
            case ($urandom_range(5))
                0: return 20'd22050;
                1: return 20'd44100;
                2: return 20'd48000;
                3: return 20'd88200;
                4: return 20'd96000;
                default: return 20'd192000;
            endcase
        end
        return RATE_W'($urandom_range(20'hFFFFF, 1));
    endfunction

    function automatic logic [TEMPO_W-1:0] pick_tempo();
        int r;
        r = $urandom_range(99);
        if (r < 20) begin
            return tr_tempo;
        end else if (r < 35) begin
            return TEMPO_W'($urandom);
        end
        return TEMPO_W'($urandom_range(tapq_pkg::TEMPO_MAX, tapq_pkg::TEMPO_MIN));
    endfunction

    // One well-formed stretch of playback: start or continue, a run of blocks
    // with the odd tempo, rate or position change in between, then usually stop.
    task automatic play_session();
        t_transport_cmd c;
        int             r;
        c = random_cmd($urandom_range(1) ? tapq_pkg::CMD_START : tapq_pkg::CMD_CONTINUE);
        offer_cmd(c, 1'b0, no_window);
        repeat ($urandom_range(12, 2)) begin
            r = $urandom_range(99);
            if (r < 12) begin
                c = random_cmd(tapq_pkg::CMD_SET_TEMPO);
                c.tempo = pick_tempo();
                offer_cmd(c, 1'b0, no_window);
            end else if (r < 20) begin
                c = random_cmd(tapq_pkg::CMD_SET_RATE);
                c.rate = pick_rate();
                offer_cmd(c, 1'b0, no_window);
            end else if (r < 25) begin
                offer_cmd(random_cmd(tapq_pkg::CMD_SET_POS), 1'b0, no_window);
            end
            c = random_cmd(tapq_pkg::CMD_BEGIN_BLK);
            c.count = pick_count();
            offer_cmd(c, 1'b0, no_window);
            if ($urandom_range(19) != 0) begin
                offer_cmd(random_cmd(tapq_pkg::CMD_END_BLK), 1'b0, no_window);
            end
        end
        if ($urandom_range(3) != 0) begin
            offer_cmd(random_cmd(tapq_pkg::CMD_STOP), 1'b0, no_window);
        end
    endtask

    task automatic run_random(input int target);
        t_transport_cmd c;
        while (cmds_sent < target) begin
            if ($urandom_range(99) < 80) begin
                play_session();
            end else begin
                c = random_cmd(CMD_W'($urandom));
                if ($urandom_range(1) == 0) begin
                    c.count = pick_count();
                    c.rate  = pick_rate();
                    c.tempo = pick_tempo();
                end
                offer_cmd(c, 1'b0, no_window);
            end
        end
    endtask

    initial begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_window left_over;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = tapq_pkg::CFG_SAMPLE_RATE;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_cmd          = tapq_pkg::CMD_PREPARE;
        i_sample_count = '0;
        i_rate_hz      = '0;
        i_tempo_bpm    = '0;
        i_position_ppq = '0;
        no_window      = '{default: '0};

        dir_row(tapq_pkg::CMD_STOP,      16'sd0,     20'd0,     17'd0,     48'h0, 1'b1,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_BEGIN_BLK, 16'sd256,   20'd0,     17'd0,     48'h0, 1'b1,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_END_BLK,   16'sd0,     20'd0,     17'd0,     48'h0, 1'b1,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_START,     16'sd0,     20'd0,     17'd0,     48'h0, 1'b1,
                '0, '0, '0, 1'b1);
        dir_row(tapq_pkg::CMD_BEGIN_BLK, 16'sd22050, 20'd0,     17'd0,     48'h0, 1'b1,
                '0, PPQ_ONE, '0, 1'b1);
        dir_row(tapq_pkg::CMD_END_BLK,   16'sd0,     20'd0,     17'd0,     48'h0, 1'b1,
                PPQ_ONE, PPQ_ONE, 48'd22050, 1'b1);
        dir_row(tapq_pkg::CMD_BEGIN_BLK, 16'sh8000,  20'd0,     17'd0,     48'h0, 1'b1,
                PPQ_ONE, PPQ_ONE, 48'd22050, 1'b1);
        dir_row(tapq_pkg::CMD_BEGIN_BLK, 16'sh7FFF,  20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_END_BLK,   16'sd0,     20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_TEMPO, 16'sd0,     20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_TEMPO, 16'sd0,     20'd0,     17'd1000,  48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_TEMPO, 16'sd0,     20'd0,     17'h1FFFF, 48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_RATE,  16'sd0,     20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_RATE,  16'sd0,     20'hFFFFF, 17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_RATE,  16'sd0,     20'hFFFFF, 17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_POS,   16'sd0,     20'd0,     17'd0,
                48'h7FFF_FFFF_FFFF, 1'b0, '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_BEGIN_BLK, 16'sh7FFF,  20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_SET_POS,   16'sd0,     20'd0,     17'd0,
                48'h8000_0000_0000, 1'b0, '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_STOP,      16'sd0,     20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_BEGIN_BLK, 16'sd100,   20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_CONTINUE,  16'sd0,     20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(CMD_UNUSED_HI,           16'shFFFF,  20'hFFFFF, 17'h1FFFF,
                48'hFFFF_FFFF_FFFF, 1'b0, '0, '0, '0, 1'b0);
        dir_row(CMD_UNUSED_LO,           16'sd0,     20'd0,     17'd0,     48'h0, 1'b0,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_PREPARE,   16'sd0,     20'd48000, 17'd0,     48'h0, 1'b1,
                '0, '0, '0, 1'b0);
        dir_row(tapq_pkg::CMD_RESET,     16'sd0,     20'd0,     17'd0,     48'h0, 1'b1,
                '0, '0, '0, 1'b0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        cfg_rate  = tapq_pkg::RATE_RESET;
        cfg_tempo = tapq_pkg::TEMPO_RESET;
        clear_transport_state();
        tr_rate  = bound_rate(cfg_rate);
        tr_tempo = bound_tempo(cfg_tempo);
        repeat (4) @(negedge i_clk);

        write_reg(tapq_pkg::CFG_SAMPLE_RATE, 20'd96000);
        write_reg(tapq_pkg::CFG_TEMPO, 20'd5120);

        send_idle_pct = 11;
        recv_idle_pct = 66;
        foreach (directed_rows[k]) begin
            offer_cmd(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].want);
        end
        wait_windows_drained();

        write_reg(tapq_pkg::CFG_SAMPLE_RATE, 20'd1);
        write_reg(tapq_pkg::CFG_TEMPO, 20'd76800);
        run_random(675);
        wait_windows_drained();

        write_reg(tapq_pkg::CFG_SAMPLE_RATE, 20'hFFFFF);
        write_reg(tapq_pkg::CFG_TEMPO, 20'd0);
        send_idle_pct = 66;
        recv_idle_pct = 11;
        run_random(1275);
        wait_windows_drained();

        write_reg(tapq_pkg::CFG_SAMPLE_RATE, 20'd0);
        write_reg(tapq_pkg::CFG_TEMPO, 20'h1FFFF);
        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_off_armed = 1'b1;
        run_random(1315);
        wait_windows_drained();

        run_random(1900);
        wait_windows_drained();
        repeat (200) @(negedge i_clk);

        while (pending_windows.size() != 0) begin
            left_over = pending_windows.pop_front();
            flag_mismatch("window never returned", '0, left_over.win_start);
        end

        $display("summary: %0d commands, %0d windows compared, %0d blocks while playing",
                 cmds_sent, windows_checked, blocks_played);
        $display("summary: %0d re-anchors on rate or tempo change, %0d register writes",
                 anchors_moved, reg_writes);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/tapq_pkg.sv
sv/tapq_ppq_unit.sv
sv/tempo_anchored_ppq_transport_core.sv
sv/tapq_checker.sv
verif/tb_tempo_anchored_ppq_transport_core.sv
